/* rtl/core/checksummed_frame_receiver_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the checksummed frame receiver
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH
`define CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRX_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("crx assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRX_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("crx assertion failed");

`endif

/* rtl/core/crx_pkg.sv */
// ----------------------------------------------------------------------------
// crx_pkg
// Shared types and constants of the checksummed frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crx_pkg;

	localparam logic [7:0] HEADER_BYTE = 8'hA5;
	localparam logic [7:0] TAIL_BYTE   = 8'h5A;
	localparam logic [7:0] LEN_RESET   = 8'd6;
	localparam logic [7:0] COUNT_MAX   = 8'hFF;

	// payload bytes that land in the channel registers
	localparam int unsigned CAPTURE_BYTES = 6;

	// result queue between front and output side
	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	typedef logic [7:0] byte_t;

	typedef struct packed {
		logic signed [15:0] channel_zero;
		logic signed [15:0] channel_one;
		logic signed [15:0] channel_two;
	} chan_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_PAYLOAD = 4'b0010,
		PH_CHECK   = 4'b0100,
		PH_TAIL    = 4'b1000
	} phase_t;

endpackage

`default_nettype wire

/* rtl/core/crx_rx_if.sv */
// ----------------------------------------------------------------------------
// crx_rx_if
// Byte stream channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crx_rx_if;
	logic           valid;
	logic           ready;
	crx_pkg::byte_t rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* rtl/core/crx_chan_if.sv */
// ----------------------------------------------------------------------------
// crx_chan_if
// Result channel: valid/ready handshake with three signed channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crx_chan_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] channel_zero;
	logic signed [15:0] channel_one;
	logic signed [15:0] channel_two;

	modport source (output valid, output channel_zero, output channel_one,
		output channel_two, input ready);
	modport sink   (input valid, input channel_zero, input channel_one,
		input channel_two, output ready);
endinterface

`default_nettype wire

/* rtl/core/checksummed_frame_receiver.sv */
// ----------------------------------------------------------------------------
// checksummed_frame_receiver
// Parses header / payload / checksum / tail frames from a byte stream and
// delivers three signed 16-bit channels per good frame.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+-------------
//  rx       | in  | rx_byte[7:0]                             | valid/ready
//  chan     | out | channel_zero/one/two, signed [15:0] each | valid/ready
//  cfg      | in  | cfg_wdata[7:0] = frame_payload_length    | cfg_we only
//
//  One byte is taken per cycle; the parser state is registered.
//  A good frame's channels enter the queue on its tail transfer.
//  A two-entry result queue decouples the parser from chan; rx.ready drops
//  only while that queue is full.
//  Reset is asynchronous; length returns to 6 and the parser to hunting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module checksummed_frame_receiver (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire crx_pkg::byte_t   cfg_wdata,
	crx_rx_if.sink                rx,
	crx_chan_if.source            chan
);
	import crx_pkg::*;

	logic       push;
	chan_word_t push_word;
	fifo_stat_t stat;

	crx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx),
		.stat      (stat),
		.push      (push),
		.push_word (push_word)
	);

	crx_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.stat      (stat),
		.chan      (chan)
	);

endmodule

`default_nettype wire

/* rtl/core/crx_front.sv */
// ----------------------------------------------------------------------------
// crx_front
// Frame parser: hunts for the header, sums and captures payload, checks
// checksum and tail, and pushes one channel word per good frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crx_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_we,
	input  wire crx_pkg::byte_t   cfg_wdata,
	crx_rx_if.sink                rx,
	input  wire crx_pkg::fifo_stat_t stat,
	output logic                  push,
	output crx_pkg::chan_word_t   push_word
);
	import crx_pkg::*;

	phase_t     phase_q;
	byte_t      len_q;
	byte_t      count_q;
	byte_t      sum_q;
	chan_word_t chan_q;

	logic       xfer;
	logic [8:0] next_count;
	logic       payload_done;

	assign rx.ready = !stat.full;
	assign xfer     = rx.valid && rx.ready;

	assign next_count   = {1'b0, count_q} + 9'd1;
	assign payload_done = (next_count >= {1'b0, len_q}) || (next_count >= {1'b0, COUNT_MAX});

	assign push      = xfer && (phase_q == PH_TAIL) && (rx.rx_byte == TAIL_BYTE);
	assign push_word = chan_q;

	// length register takes effect at once, also mid-frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= LEN_RESET;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			sum_q   <= '0;
			chan_q  <= '0;
		end else if (xfer) begin
			case (phase_q)
				PH_HUNT: begin
					if (rx.rx_byte == HEADER_BYTE) begin
						count_q <= '0;
						sum_q   <= '0;
						phase_q <= (len_q == '0) ? PH_CHECK : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					// bytes stay captured even if the frame fails later
					if (count_q < 8'(CAPTURE_BYTES)) begin
						case (count_q[2:0])
							3'd0:    chan_q.channel_zero[7:0]  <= rx.rx_byte;
							3'd1:    chan_q.channel_zero[15:8] <= rx.rx_byte;
							3'd2:    chan_q.channel_one[7:0]   <= rx.rx_byte;
							3'd3:    chan_q.channel_one[15:8]  <= rx.rx_byte;
							3'd4:    chan_q.channel_two[7:0]   <= rx.rx_byte;
							3'd5:    chan_q.channel_two[15:8]  <= rx.rx_byte;
							default: ;
						endcase
					end
					sum_q   <= sum_q + rx.rx_byte;
					count_q <= next_count[8] ? COUNT_MAX : next_count[7:0];
					if (payload_done) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_q <= (rx.rx_byte == sum_q) ? PH_TAIL : PH_HUNT;
				end
				PH_TAIL: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= PH_HUNT;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/crx_fifo.sv */
// ----------------------------------------------------------------------------
// crx_fifo
// Short result queue; its head drives the output channel directly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crx_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   push,
	input  wire crx_pkg::chan_word_t push_word,
	output crx_pkg::fifo_stat_t   stat,
	crx_chan_if.source            chan
);
	import crx_pkg::*;

	chan_word_t       mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	chan_word_t       head;

	assign stat.full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	assign head              = mem_q[rd_ptr_q];
	assign chan.valid        = !stat.empty;
	assign chan.channel_zero = head.channel_zero;
	assign chan.channel_one  = head.channel_one;
	assign chan.channel_two  = head.channel_two;

	assign pop = chan.valid && chan.ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/crx_checker.sv */
// ----------------------------------------------------------------------------
// crx_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "checksummed_frame_receiver_assert.svh"

module crx_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 rx_valid,
	input wire                 rx_ready,
	input wire crx_pkg::byte_t rx_byte,
	input wire                 out_valid,
	input wire                 out_ready,
	input wire [15:0]          out_zero,
	input wire [15:0]          out_one,
	input wire [15:0]          out_two
);
	import crx_pkg::*;

	logic [47:0] out_word;

	assign out_word = {out_zero, out_one, out_two};

	// a stalled result holds
	`CRX_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))

	// a new result only follows a byte transfer
	`CRX_ASSERT_IMP(a_out_after_xfer, clk, arst_n, $rose(out_valid), $past(rx_valid && rx_ready))

	// and that byte was the tail
	`CRX_ASSERT_IMP(a_out_after_tail, clk, arst_n, $rose(out_valid), $past(rx_byte) == TAIL_BYTE)

	// with nothing queued the input never stalls
	`CRX_ASSERT_IMP(a_ready_when_idle, clk, arst_n, !out_valid, rx_ready)

endmodule

bind checksummed_frame_receiver crx_checker u_crx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rx_valid  (rx.valid),
	.rx_ready  (rx.ready),
	.rx_byte   (rx.rx_byte),
	.out_valid (chan.valid),
	.out_ready (chan.ready),
	.out_zero  (chan.channel_zero),
	.out_one   (chan.channel_one),
	.out_two   (chan.channel_two)
);

`default_nettype wire

/* sim/checksummed_frame_receiver_tb.sv */
// ----------------------------------------------------------------------------
// checksummed_frame_receiver_tb
// Streams bytes into the frame receiver: good frames, frames with a broken
// checksum or tail, cut frames and noise. The lengths run from zero to 255,
// and the length also changes in the middle of a frame. A parser model
// beside the block predicts the channel words, and each word that comes out
// is checked against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module checksummed_frame_receiver_tb;
	import crx_pkg::*;

	typedef enum int {
		FR_GOOD,
		FR_BAD_SUM,
		FR_BAD_TAIL,
		FR_CUT,
		FR_NOISE
	} frame_kind_t;

	localparam int HOLD_CYCLES  = 120;
	localparam int SETTLE_TICKS = 4;

	logic  clk;
	logic  arst_n;
	logic  cfg_we;
	byte_t cfg_wdata;

	crx_rx_if   rx();
	crx_chan_if chan();

	checksummed_frame_receiver dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx        (rx),
		.chan      (chan)
	);

	// bytes waiting for the driver, channel words waiting for the block
	byte_t      tx_bytes[$];
	chan_word_t expected_channels[$];
	int         bytes_queued;
	int         err_count;
	int         snd_idle_pct;
	int         rcv_idle_pct;
	bit         hold_req;

	// parser model
	phase_t      m_phase;
	byte_t       m_len;
	byte_t       m_count;
	byte_t       m_sum;
	logic [15:0] m_chan[3];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("TB_ERROR");
		$finish;
	end

	function automatic bit frame_parse_step(input byte_t b, output chan_word_t w);
		int nxt;
		w = '0;
		case (m_phase)
			PH_HUNT: begin
				if (b == HEADER_BYTE) begin
					m_count = '0;
					m_sum   = '0;
					m_phase = (m_len == 8'd0) ? PH_CHECK : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				if (m_count < CAPTURE_BYTES) begin
					if (m_count[0])
						m_chan[m_count >> 1][15:8] = b;
					else
						m_chan[m_count >> 1][7:0] = b;
				end
				m_sum = m_sum + b;
				nxt = int'(m_count) + 1;
				if (nxt >= int'(m_len) || nxt >= 255)
					m_phase = PH_CHECK;
				m_count = (nxt > 255) ? COUNT_MAX : byte_t'(nxt);
			end
			PH_CHECK: begin
				m_phase = (b == m_sum) ? PH_TAIL : PH_HUNT;
			end
			default: begin
				m_phase = PH_HUNT;
				if (b == TAIL_BYTE) begin
					w.channel_zero = m_chan[0];
					w.channel_one  = m_chan[1];
					w.channel_two  = m_chan[2];
					return 1'b1;
				end
			end
		endcase
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endtask

	// driver: a new byte only once the current one has transferred
	always @(posedge clk) begin
		if (!arst_n) begin
			rx.valid   <= 1'b0;
			rx.rx_byte <= '0;
		end else if (!rx.valid || rx.ready) begin
			if (tx_bytes.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
				rx.valid   <= 1'b1;
				rx.rx_byte <= tx_bytes.pop_front();
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin : rcv
		int  hold_left;
		bit  hold_done;
		if (!arst_n) begin
			chan.ready <= 1'b0;
			hold_left = 0;
			hold_done = 1'b0;
		end else if (hold_left > 0) begin
			chan.ready <= 1'b0;
			hold_left--;
		end else if (hold_req && !hold_done) begin
			chan.ready <= 1'b0;
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end else begin
			chan.ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	// monitor: model update on every byte transfer, check on every word transfer
	always @(posedge clk) begin : mon
		chan_word_t want;
		chan_word_t got;
		if (arst_n) begin
			if (cfg_we)
				m_len = cfg_wdata;
			if (rx.valid && rx.ready) begin
				if (frame_parse_step(rx.rx_byte, want))
					expected_channels.push_back(want);
			end
			if (chan.valid && chan.ready) begin
				got.channel_zero = chan.channel_zero;
				got.channel_one  = chan.channel_one;
				got.channel_two  = chan.channel_two;
				if (expected_channels.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h %h %h",
						got.channel_zero, got.channel_one, got.channel_two));
				end else begin
					want = expected_channels.pop_front();
					if (got.channel_zero !== want.channel_zero ||
						got.channel_one !== want.channel_one ||
						got.channel_two !== want.channel_two)
						report_mismatch($sformatf("expected %h %h %h, got %h %h %h",
							want.channel_zero, want.channel_one, want.channel_two,
							got.channel_zero, got.channel_one, got.channel_two));
				end
			end
		end
	end

	function automatic void push_byte(input byte_t b);
		tx_bytes.push_back(b);
		bytes_queued++;
	endfunction

	function automatic void push_frame(input int len, input frame_kind_t kind);
		byte_t s;
		int    n;
		s = '0;
		if (kind == FR_NOISE) begin
			repeat ($urandom_range(1, 4))
				push_byte(byte_t'($urandom));
			return;
		end
		push_byte(HEADER_BYTE);
		n = (kind == FR_CUT) ? $urandom_range(0, len) : len;
		for (int i = 0; i < n; i++) begin
			byte_t b;
			b = byte_t'($urandom);
			s = s + b;
			push_byte(b);
		end
		if (kind == FR_CUT)
			return;
		if (kind == FR_BAD_SUM) begin
			push_byte(s ^ byte_t'($urandom_range(1, 255)));
			return;
		end
		push_byte(s);
		push_byte((kind == FR_BAD_TAIL) ? TAIL_BYTE ^ byte_t'($urandom_range(1, 255))
			: TAIL_BYTE);
	endfunction

	// everything sent and delivered, then time for a frame in flight to settle
	task automatic drain();
		do
			@(negedge clk);
		while (tx_bytes.size() != 0 || rx.valid || expected_channels.size() != 0);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_length(input byte_t len);
		drain();
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= len;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic random_frames(input byte_t len, input int nbytes);
		int r;
		write_length(len);
		bytes_queued = 0;
		while (bytes_queued < nbytes) begin
			r = $urandom_range(99);
			if (r < 72)
				push_frame(len, FR_GOOD);
			else if (r < 80)
				push_frame(len, FR_BAD_SUM);
			else if (r < 87)
				push_frame(len, FR_BAD_TAIL);
			else if (r < 93)
				push_frame(len, FR_CUT);
			else
				push_frame(len, FR_NOISE);
		end
	endtask

	// length rewritten while a frame is half received
	task automatic length_switch(input byte_t len_a, input int n_a, input byte_t len_b,
		input int n_b);
		byte_t s;
		byte_t b;
		s = '0;
		write_length(len_a);
		push_byte(HEADER_BYTE);
		repeat (n_a) begin
			b = byte_t'($urandom);
			s = s + b;
			push_byte(b);
		end
		write_length(len_b);
		repeat (n_b) begin
			b = byte_t'($urandom);
			s = s + b;
			push_byte(b);
		end
		push_byte(s);
		push_byte(TAIL_BYTE);
	endtask

	initial begin
		byte_t directed[$];
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		rx.valid     = 1'b0;
		rx.rx_byte   = '0;
		chan.ready   = 1'b0;
		err_count    = 0;
		bytes_queued = 0;
		hold_req     = 1'b0;
		snd_idle_pct = 7;
		rcv_idle_pct = 71;
		m_phase      = PH_HUNT;
		m_len        = LEN_RESET;
		m_count      = '0;
		m_sum        = '0;
		m_chan       = '{default: '0};
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// extreme channel values; header byte inside a frame with a bad checksum
		// that is itself a header; a good checksum followed by a header as tail
		directed = '{8'hA5, 8'hFF, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFC, 8'h5A,
			8'hA5, 8'hA5, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'hA5,
			8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5};
		foreach (directed[i])
			push_byte(directed[i]);

		for (int stage = 0; stage < 3; stage++) begin
			drain();
			case (stage)
				0: begin
					snd_idle_pct = 7;
					rcv_idle_pct = 71;
				end
				1: begin
					snd_idle_pct = 71;
					rcv_idle_pct = 7;
				end
				default: begin
					snd_idle_pct = 0;
					rcv_idle_pct = 0;
				end
			endcase
			if (stage == 2) begin
				write_length(LEN_RESET);
				hold_req = 1'b1;
			end
			random_frames(LEN_RESET, 260);
			random_frames((stage == 0) ? 8'd0 : byte_t'($urandom_range(1, 5)), 60);
			random_frames(byte_t'($urandom_range(7, 40)), 100);
			if (stage == 1) begin
				length_switch(8'd200, 30, 8'd10, 1);
				length_switch(8'd8, 4, 8'd12, 8);
			end
			if (stage == 2) begin
				write_length(COUNT_MAX);
				push_frame(255, FR_GOOD);
			end
		end

		drain();
		repeat (20) @(negedge clk);
		if (err_count == 0 && expected_channels.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/crx_pkg.sv
rtl/core/crx_rx_if.sv
rtl/core/crx_chan_if.sv
rtl/core/crx_front.sv
rtl/core/crx_fifo.sv
rtl/core/checksummed_frame_receiver.sv
rtl/core/crx_checker.sv
sim/checksummed_frame_receiver_tb.sv
